[hdl/jet_pkg.sv]
// Shared definitions for the Julia escape-time core: widths, register
// indexes, reset values and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jet_pkg;

  // Fixed-point format of all coordinates (Q5.27)
  localparam int FRAC_BITS   = 27;
  localparam int MAX_DIM_DEF = 2048;

  // Field and register widths
  localparam int PIX_W      = 11;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Iterate operand width: covers +/-2^(FRAC_BITS+1), the only range ever squared
  localparam int MW = FRAC_BITS + 3;
  localparam int PW = 2 * MW;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_RE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

  // Reset values
  localparam logic [COORD_W-1:0] RST_START_RE = 32'hF000_0000;  // -2.0
  localparam logic [COORD_W-1:0] RST_START_IM = 32'hF000_0000;  // -2.0
  localparam logic [STEP_W-1:0]  RST_STEP_RE  = 31'd671089;
  localparam logic [STEP_W-1:0]  RST_STEP_IM  = 31'd671089;
  localparam logic [COORD_W-1:0] RST_CONST_RE = 32'hF999_999A;  // about -0.8
  localparam logic [COORD_W-1:0] RST_CONST_IM = 32'd20937965;   // about 0.156
  localparam logic [ITER_W-1:0]  RST_MAX_ITER = 10'd50;

  // Configuration register set
  typedef struct packed {
    logic [COORD_W-1:0] start_re;
    logic [COORD_W-1:0] start_im;
    logic [STEP_W-1:0]  step_re;
    logic [STEP_W-1:0]  step_im;
    logic [COORD_W-1:0] const_re;
    logic [COORD_W-1:0] const_im;
    logic [ITER_W-1:0]  max_iter;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch pixel indices of the accepted request
    logic load;     // form start point, clear count
    logic mul;      // register x*x, y*y, x*y
    logic step;     // write z = z*z + c, bump count
    logic emit;     // write the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic limit_hit;  // count reached max_iter
    logic out_range;  // |re| or |im| above 2.0
    logic escaped;    // |z|^2 above 4.0
  } dp_stat_t;

endpackage

`default_nettype wire

[hdl/jet_cfg.sv]
// Configuration register file of the Julia escape-time core.
// Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jet_cfg (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [jet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [jet_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output jet_pkg::cfg_t                 cfg
);
  import jet_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_RE: cfg_nxt.start_re = cfg_wdata;
        REG_START_IM: cfg_nxt.start_im = cfg_wdata;
        REG_STEP_RE:  cfg_nxt.step_re  = cfg_wdata[STEP_W-1:0];
        REG_STEP_IM:  cfg_nxt.step_im  = cfg_wdata[STEP_W-1:0];
        REG_CONST_RE: cfg_nxt.const_re = cfg_wdata;
        REG_CONST_IM: cfg_nxt.const_im = cfg_wdata;
        REG_MAX_ITER: cfg_nxt.max_iter = cfg_wdata[ITER_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_re <= RST_START_RE;
      cfg_r.start_im <= RST_START_IM;
      cfg_r.step_re  <= RST_STEP_RE;
      cfg_r.step_im  <= RST_STEP_IM;
      cfg_r.const_re <= RST_CONST_RE;
      cfg_r.const_im <= RST_CONST_IM;
      cfg_r.max_iter <= RST_MAX_ITER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/jet_ctrl.sv]
// Sequencer of the Julia escape-time core: request handshake, iteration
// phases and the result register's valid flag. Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jet_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  wire jet_pkg::dp_stat_t  stat,
  output jet_pkg::dp_cmd_t        cmd
);
  import jet_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Phase sequencing: LOAD, then MUL/ADD pairs until limit, out-of-range or escape
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (stat.limit_hit || stat.out_range) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (stat.escaped) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        // wait for a free result register
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/jet_dpath.sv]
// Datapath of the Julia escape-time core: start point, registered complex
// square, escape test, iteration count and result register. Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jet_dpath #(
  parameter int MAX_DIM = jet_pkg::MAX_DIM_DEF  // power of two
) (
  input  wire                       clk,
  input  wire [jet_pkg::PIX_W-1:0]  in_pix_col,
  input  wire [jet_pkg::PIX_W-1:0]  in_pix_row,
  input  wire jet_pkg::cfg_t        cfg,
  input  wire jet_pkg::dp_cmd_t     cmd,
  output jet_pkg::dp_stat_t         stat,
  output logic [jet_pkg::PIX_W-1:0] out_col,
  output logic [jet_pkg::PIX_W-1:0] out_row,
  output logic [jet_pkg::ITER_W-1:0] out_iter_count
);
  import jet_pkg::*;

  // Index bits that survive the wrap at MAX_DIM
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CM_W  = (DIM_W < PIX_W) ? DIM_W : PIX_W;
  // Held z width: start + step*index, with sign and carry
  localparam int ZW    = STEP_W + CM_W + 2;
  localparam int SP_W  = STEP_W + CM_W;

  localparam logic signed [ZW-1:0] Z_LIM   = ZW'(1) <<< (FRAC_BITS + 1);
  localparam logic signed [ZW-1:0] Z_LIM_N = -Z_LIM;
  localparam logic [PW:0]          ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  logic [PIX_W-1:0]     col_r, row_r;
  logic signed [ZW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [ITER_W-1:0]    n_r, n_nxt;
  logic signed [PW-1:0] pxx_r, pyy_r, pxy_r;
  logic signed [PW-1:0] pxx_nxt, pyy_nxt, pxy_nxt;
  logic [PIX_W-1:0]     out_col_r, out_row_r;
  logic [ITER_W-1:0]    out_iter_r;

  logic [SP_W-1:0]      ofs_re, ofs_im;
  logic signed [ZW-1:0] x_init, y_init, x_iter, y_iter;
  logic signed [ZW-1:0] c_re, c_im;
  logic signed [MW-1:0] xs, ys;
  logic [PW:0]          sq_sum;

  // Start point: start + step * (index mod MAX_DIM), product at full width
  assign ofs_re = SP_W'(cfg.step_re) * SP_W'(col_r[CM_W-1:0]);
  assign ofs_im = SP_W'(cfg.step_im) * SP_W'(row_r[CM_W-1:0]);
  assign x_init = ZW'($signed(cfg.start_re)) + $signed({2'b00, ofs_re});
  assign y_init = ZW'($signed(cfg.start_im)) + $signed({2'b00, ofs_im});

  // Squares and cross product; operands are only valid when in range
  assign xs      = x_r[MW-1:0];
  assign ys      = y_r[MW-1:0];
  assign pxx_nxt = PW'(xs) * PW'(xs);
  assign pyy_nxt = PW'(ys) * PW'(ys);
  assign pxy_nxt = PW'(xs) * PW'(ys);

  // z*z + c from registered products; arithmetic shift floors
  assign c_re   = ZW'($signed(cfg.const_re));
  assign c_im   = ZW'($signed(cfg.const_im));
  assign x_iter = ZW'(pxx_r >>> FRAC_BITS) - ZW'(pyy_r >>> FRAC_BITS) + c_re;
  assign y_iter = ZW'(pxy_r >>> (FRAC_BITS - 1)) + c_im;

  // Exact |z|^2 against 4.0 at scale 2^(2F)
  assign sq_sum = (PW + 1)'($unsigned(pxx_r)) + (PW + 1)'($unsigned(pyy_r));

  assign stat.limit_hit = (n_r >= cfg.max_iter);
  assign stat.out_range = (x_r > Z_LIM) || (x_r < Z_LIM_N) ||
                          (y_r > Z_LIM) || (y_r < Z_LIM_N);
  assign stat.escaped   = (sq_sum > ESC_LIM);

  // z and count update
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    n_nxt = n_r;
    if (cmd.load) begin
      x_nxt = x_init;
      y_nxt = y_init;
      n_nxt = '0;
    end else if (cmd.step) begin
      x_nxt = x_iter;
      y_nxt = y_iter;
      n_nxt = n_r + ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    n_r <= n_nxt;
    if (cmd.capture) begin
      col_r <= in_pix_col;
      row_r <= in_pix_row;
    end
    if (cmd.mul) begin
      pxx_r <= pxx_nxt;
      pyy_r <= pyy_nxt;
      pxy_r <= pxy_nxt;
    end
    if (cmd.emit) begin
      out_col_r  <= col_r;
      out_row_r  <= row_r;
      out_iter_r <= n_r;
    end
  end

  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_iter_count = out_iter_r;

endmodule

`default_nettype wire

[hdl/julia_escape_time_core.sv]
// Top level of the Julia escape-time core: config registers, sequencer and
// datapath. Depends on jet_pkg, jet_cfg, jet_ctrl, jet_dpath.
//
//   Channel  Signals                                         Dir  Transfer
//   -------  ----------------------------------------------  ---  ---------------------
//   in       in_valid, in_ready, in_pix_col, in_pix_row      in   valid & ready
//   out      out_valid, out_ready, out_col, out_row,
//            out_iter_count                                  out  valid & ready
//   cfg      cfg_we, cfg_index, cfg_wdata                    in   cfg_we, no wait
//
// One pixel at a time: the limit or a far start point ends a pixel in its multiply
// phase, |z|^2 passing 4.0 ends it in its add/compare phase. Each iteration is one
// multiply phase and one add/compare phase around the shared z registers.
// Synchronous active-low reset loads the register defaults and idles the core.
// A stalled result stays in the output register; a new pixel is accepted
// meanwhile and waits in its final phase until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_core #(
  parameter int MAX_DIM = jet_pkg::MAX_DIM_DEF  // power of two, 16..4096
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [jet_pkg::PIX_W-1:0]       in_pix_col,
  input  wire [jet_pkg::PIX_W-1:0]       in_pix_row,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [jet_pkg::PIX_W-1:0]      out_col,
  output logic [jet_pkg::PIX_W-1:0]      out_row,
  output logic [jet_pkg::ITER_W-1:0]     out_iter_count,
  input  wire                            cfg_we,
  input  wire [jet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [jet_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import jet_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  jet_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  jet_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk            (clk),
    .in_pix_col     (in_pix_col),
    .in_pix_row     (in_pix_row),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_iter_count (out_iter_count)
  );

  // One pixel in flight: an accepted request closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a pixel is in flight");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  // A new result only appears through the write command
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("out_valid raised without a result write");

endmodule

`default_nettype wire
